### hw/rtl/ccd_pkg.sv
package ccd_pkg;

  localparam int unsigned MaxPayloadDefault = 256;
  localparam int unsigned HeaderBytes       = 3;
  localparam int unsigned CountWidth        = 16;
  localparam int unsigned OutDataWidth      = 48;

  localparam logic [7:0]  Delimiter  = 8'h00;
  localparam logic [7:0]  FullCode   = 8'hFF;
  localparam logic [15:0] CountSat   = 16'hFFFF;

  typedef enum logic {
    KIND_DATA    = 1'b0,
    KIND_VERDICT = 1'b1
  } kind_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_TRUNC    = 3'd1,
    ST_SHORT    = 3'd2,
    ST_MISMATCH = 3'd3,
    ST_TOO_LONG = 3'd4
  } status_e;

endpackage

### hw/rtl/cobs_command_deframer.sv
// COBS command deframer.
// Slave side (s_axis_*) takes one received link byte per transfer; a zero
// byte closes a frame. Non-zero bytes are COBS-decoded. The first three
// decoded bytes form the header (command code, big-endian payload length),
// later bytes come out at once as indexed payload bytes (tuser = 0).
// At each delimiter of a non-empty frame one verdict comes out (tuser = 1)
// carrying status, command code and payload length. The consumer drops the
// payload bytes of a frame unless its verdict is ok. Empty frames give
// nothing; payload past MAX_PAYLOAD is not sent and gives a too-long
// verdict unless the frame is truncated. A byte is registered on
// acceptance and then decoded into the output register. One byte is taken
// every cycle while the master side keeps up; the decode state update is
// the loop that sets this.
// Reset clears all frame state and empties both registers. When the master
// side stalls, the output holds and the input register fills, then
// s_axis_tready_o drops until the result is taken.
module cobs_command_deframer
  import ccd_pkg::*;
#(
  parameter int unsigned MAX_PAYLOAD = MaxPayloadDefault
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    s_axis_tvalid_i,
  output logic                    s_axis_tready_o,
  input  logic [7:0]              s_axis_tdata_i,   // [7:0] rx_byte
  output logic                    m_axis_tvalid_o,
  input  logic                    m_axis_tready_i,
  // [7:0] payload_byte, [15:8] payload_index, [18:16] status,
  // [26:19] command_code, [42:27] payload_length, [47:43] zero
  output logic [OutDataWidth-1:0] m_axis_tdata_o,
  output logic                    m_axis_tuser_o    // [0] kind
);

  localparam logic [CountWidth:0]   MaxLen = (CountWidth+1)'(MAX_PAYLOAD);
  localparam logic [CountWidth-1:0] HdrCnt = CountWidth'(HeaderBytes);

  logic       in_valid_q, in_valid_d;
  logic [7:0] in_byte_q;

  logic                  started_q, started_d;
  logic [7:0]            group_left_q, group_left_d;
  logic                  group_full_q, group_full_d;
  logic [CountWidth-1:0] count_q, count_d;
  logic [7:0]            code_q, code_d;
  logic [15:0]           length_q, length_d;
  logic                  overflow_q, overflow_d;

  logic        out_valid_q, out_valid_d;
  kind_e       out_kind_q, out_kind_d;
  logic [7:0]  out_byte_q, out_byte_d;
  logic [7:0]  out_index_q, out_index_d;
  status_e     out_status_q, out_status_d;
  logic [7:0]  out_code_q, out_code_d;
  logic [15:0] out_length_q, out_length_d;

  logic                  out_free, proc;
  logic                  dec_en;
  logic [7:0]            dec_val;
  logic [CountWidth-1:0] pos;
  logic [CountWidth:0]   len_plus;

  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign proc            = in_valid_q && out_free;
  assign s_axis_tready_o = !in_valid_q || proc;
  assign in_valid_d      = (s_axis_tvalid_i && s_axis_tready_o) || (in_valid_q && !proc);
  assign pos             = count_q - HdrCnt;
  assign len_plus        = {1'b0, length_q} + (CountWidth+1)'(HeaderBytes);

  always_comb begin
    started_d    = started_q;
    group_left_d = group_left_q;
    group_full_d = group_full_q;
    count_d      = count_q;
    code_d       = code_q;
    length_d     = length_q;
    overflow_d   = overflow_q;
    out_valid_d  = out_valid_q && !m_axis_tready_i;
    out_kind_d   = out_kind_q;
    out_byte_d   = out_byte_q;
    out_index_d  = out_index_q;
    out_status_d = out_status_q;
    out_code_d   = out_code_q;
    out_length_d = out_length_q;
    dec_en       = 1'b0;
    dec_val      = in_byte_q;

    if (proc) begin
      if (in_byte_q == Delimiter) begin
        if (started_q) begin
          out_valid_d  = 1'b1;
          out_kind_d   = KIND_VERDICT;
          out_byte_d   = '0;
          out_index_d  = '0;
          out_code_d   = code_q;
          out_length_d = length_q;
          if (group_left_q != '0) begin
            out_status_d = ST_TRUNC;
          end else if (count_q < HdrCnt) begin
            out_status_d = ST_SHORT;
          end else if (overflow_q || ({1'b0, pos} > MaxLen)) begin
            out_status_d = ST_TOO_LONG;
          end else if (len_plus != {1'b0, count_q}) begin
            out_status_d = ST_MISMATCH;
          end else begin
            out_status_d = ST_OK;
          end
          started_d    = 1'b0;
          group_left_d = '0;
          group_full_d = 1'b0;
          count_d      = '0;
          code_d       = '0;
          length_d     = '0;
          overflow_d   = 1'b0;
        end
      end else if (!started_q) begin
        started_d    = 1'b1;
        group_left_d = in_byte_q - 8'd1;
        group_full_d = (in_byte_q == FullCode);
      end else if (group_left_q != '0) begin
        group_left_d = group_left_q - 8'd1;
        dec_en       = 1'b1;
      end else begin
        group_left_d = in_byte_q - 8'd1;
        group_full_d = (in_byte_q == FullCode);
        dec_en       = !group_full_q;
        dec_val      = '0;
      end

      if (dec_en) begin
        if (count_q == CountSat) begin
          overflow_d = 1'b1;
        end else begin
          count_d = count_q + CountWidth'(1);
          if (count_q == CountWidth'(0)) begin
            code_d = dec_val;
          end else if (count_q == CountWidth'(1)) begin
            length_d = {dec_val, length_q[7:0]};
          end else if (count_q == CountWidth'(2)) begin
            length_d = {length_q[15:8], dec_val};
          end else if ({1'b0, pos} >= MaxLen) begin
            overflow_d = 1'b1;
          end else begin
            out_valid_d  = 1'b1;
            out_kind_d   = KIND_DATA;
            out_byte_d   = dec_val;
            out_index_d  = pos[7:0];
            out_status_d = ST_OK;
            out_code_d   = '0;
            out_length_d = '0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q   <= 1'b0;
      started_q    <= 1'b0;
      group_left_q <= '0;
      group_full_q <= 1'b0;
      count_q      <= '0;
      code_q       <= '0;
      length_q     <= '0;
      overflow_q   <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      in_valid_q   <= in_valid_d;
      started_q    <= started_d;
      group_left_q <= group_left_d;
      group_full_q <= group_full_d;
      count_q      <= count_d;
      code_q       <= code_d;
      length_q     <= length_d;
      overflow_q   <= overflow_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_byte_q <= s_axis_tdata_i;
    end
    out_kind_q   <= out_kind_d;
    out_byte_q   <= out_byte_d;
    out_index_q  <= out_index_d;
    out_status_q <= out_status_d;
    out_code_q   <= out_code_d;
    out_length_q <= out_length_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_kind_q;
  assign m_axis_tdata_o  = {5'b0, out_length_q, out_code_q, out_status_q,
                            out_index_q, out_byte_q};

endmodule

### hw/rtl/ccd_checker.sv
module ccd_checker
  import ccd_pkg::*;
(
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    s_axis_tvalid_i,
  input logic                    s_axis_tready_o,
  input logic [7:0]              s_axis_tdata_i,
  input logic                    m_axis_tvalid_o,
  input logic                    m_axis_tready_i,
  input logic [OutDataWidth-1:0] m_axis_tdata_o,
  input logic                    m_axis_tuser_o
);

  // stalled result transfer holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("output changed under stall");

  a_verdict_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o |->
      m_axis_tdata_o[15:0] == 16'h0 &&
      (m_axis_tdata_o[18:16] == ST_OK || m_axis_tdata_o[18:16] == ST_TRUNC ||
       m_axis_tdata_o[18:16] == ST_SHORT || m_axis_tdata_o[18:16] == ST_MISMATCH ||
       m_axis_tdata_o[18:16] == ST_TOO_LONG))
    else $error("bad verdict fields");

  a_data_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tuser_o |-> m_axis_tdata_o[42:16] == 27'h0)
    else $error("payload transfer carries verdict fields");

  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[OutDataWidth-1:43] == '0)
    else $error("padding bits set");

  // input stalls only behind a stalled result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> m_axis_tvalid_o && !m_axis_tready_i)
    else $error("input stalled while output could move");

endmodule

bind cobs_command_deframer ccd_checker u_ccd_checker (.*);
